FILE: sv/msq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_pkg: shared types and constants
// Types, codes and tables shared by the melody square-tone player modules.
// ----------------------------------------------------------------------------
package msq_pkg;

	localparam int SAMPLE_RATE_DEF = 48000;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;

	// serial divider operand widths
	localparam int DIV_NW = 27;
	localparam int DIV_DW = 21;

	localparam logic [7:0]  HDR_END     = 8'h81;
	localparam logic [7:0]  HDR_LONG_MAX = 8'h80;
	localparam logic [7:0]  CODE_SILENT = 8'hFF;
	localparam logic [20:0] TIMER_HZ    = 21'd1193180;
	// note length divide by 100 as a reciprocal multiply: ceil(2^30 / 100),
	// exact for products below 2^23
	localparam logic [23:0] LEN_RECIP   = 24'd10737419;
	localparam int          LEN_SHIFT   = 30;
	localparam logic [14:0] AMP_RESET   = 15'd4800;
	localparam logic [11:0] FADE_RESET  = 12'd240;

	typedef enum logic [0:0] {
		CFG_AMPLITUDE = 1'b0,
		CFG_FADE      = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DIV_LO = 2'd1,
		PH_DIV_HI = 2'd2,
		PH_CODE   = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_MUL, S_DIV_FADE, S_TICK,
		S_DIV_FREQ, S_DIV_PER, S_FIN, S_OUT
	} bstate_t;

	// classified input word
	typedef struct packed {
		logic        is_tick;
		logic [7:0]  data;
		logic        last;
		logic        hdr_end;
		logic        code_silent;
		logic        nib_ok;
		logic [15:0] code_div;
	} entry_t;

	typedef struct packed {
		logic [15:0] sample;
		logic        note_active;
		logic        byte_taken;
		logic        note_started;
		logic        note_skipped;
		logic        melody_ended;
	} result_t;

	// timer divider of one semitone, note number 1..12
	function automatic logic [15:0] semitone_div(input logic [3:0] nib);
		logic [15:0] d;
		unique case (nib)
			4'd1:    d = 16'h4742;
			4'd2:    d = 16'h4342;
			4'd3:    d = 16'h3F7C;
			4'd4:    d = 16'h3BEC;
			4'd5:    d = 16'h388F;
			4'd6:    d = 16'h3562;
			4'd7:    d = 16'h3264;
			4'd8:    d = 16'h2F8F;
			4'd9:    d = 16'h2CE4;
			4'd10:   d = 16'h2A5F;
			4'd11:   d = 16'h2802;
			4'd12:   d = 16'h25BF;
			default: d = 16'h0000;
		endcase
		return d;
	endfunction

endpackage

FILE: sv/msq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_front: input classifier
// Accepts input words and decodes the byte fields that need no parser state.
// ----------------------------------------------------------------------------
module msq_front import msq_pkg::*; (
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [7:0] melody_byte,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       push,
	output entry_t     entry
);

	logic [15:0] sdiv;
	logic [15:0] shifted;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// compact note code: octave shift of the semitone divider, floor of one
	always_comb begin
		sdiv    = semitone_div(melody_byte[3:0]);
		shifted = sdiv >> melody_byte[7:4];
		entry.is_tick     = func;
		entry.data        = melody_byte;
		entry.last        = last_byte;
		entry.hdr_end     = (melody_byte == 8'h00) || (melody_byte == HDR_END);
		entry.code_silent = (melody_byte == CODE_SILENT);
		entry.nib_ok      = (melody_byte[3:0] >= 4'd1) && (melody_byte[3:0] <= 4'd12);
		entry.code_div    = (shifted == 16'd0) ? 16'd1 : shifted;
	end

endmodule

FILE: sv/msq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_fifo: word queue
// Short queue between the classifier and the note engine.
// ----------------------------------------------------------------------------
module msq_fifo import msq_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	input  logic   pop,
	output entry_t rd_entry,
	output logic   full,
	output logic   nonempty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         mem_q [DEPTH];
	logic [PW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_entry = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/msq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_div: serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msq_div import msq_pkg::*; #(
	parameter int NW = DIV_NW,
	parameter int DW = DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   trial, diff;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1)) && !start;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/msq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_back: note engine
// Parses queued bytes into notes and plays one square-wave sample per tick.
// ----------------------------------------------------------------------------
module msq_back import msq_pkg::*; #(
	parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [0:0]        cfg_index,
	input  logic [14:0]       cfg_data,
	input  logic              q_nonempty,
	input  entry_t            q_entry,
	output logic              pop,
	output logic              div_start,
	output logic [DIV_NW-1:0] div_num,
	output logic [DIV_DW-1:0] div_den,
	input  logic              div_done,
	input  logic [DIV_NW-1:0] div_quo,
	output logic              out_valid,
	input  logic              out_stall,
	output result_t           out_res
);

	localparam logic [14:0] AMP_LIM = 15'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic [DIV_NW-1:0] RATE_N = DIV_NW'(SAMPLE_RATE);
	// sample rate folded into the length reciprocal
	localparam logic [63:0] LEN_K = 64'(SAMPLE_RATE) * 64'(LEN_RECIP);

	bstate_t     state_q, state_d;
	logic [14:0] amp_q;
	logic [11:0] fade_len_q;
	phase_t      phase_q;
	logic [7:0]  held_q, divlo_q;
	logic [11:0] period_q, pcount_q, fused_q, k_q, per_q;
	logic [10:0] half_q;
	logic [15:0] sidx_q, nlen_q, len_q, mag_q;
	logic        note_on_q, silent_q, nsil_q;
	entry_t      cur_q;
	logic [15:0] p_sample_q;
	logic        p_taken_q, p_started_q, p_skipped_q, p_ended_q;
	result_t     out_q;
	logic        out_valid_q;

	logic [14:0] amp_c;
	logic [15:0] rem_s, k_c;
	logic        byte_ok, ex_start, tick_mul, out_free;
	logic [15:0] ex_div;
	logic [47:0] len_prod;
	logic [DIV_NW-1:0] per_t;
	logic [11:0] per_m;
	logic [14:0] n_half;
	logic [12:0] pc_next;
	logic [16:0] si_next;
	logic [11:0] per_fin;

	assign amp_c    = (amp_q > AMP_LIM) ? AMP_LIM : amp_q;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// note length in samples: rate * duration / 100
	assign len_prod = {8'b0, LEN_K[39:0]} * {40'b0, held_q};

	// fade envelope factor
	always_comb begin
		rem_s = nlen_q - 16'd1 - sidx_q;
		if (sidx_q < {4'b0, fused_q}) begin
			k_c = sidx_q;
		end else if (rem_s < {4'b0, fused_q}) begin
			k_c = rem_s;
		end else begin
			k_c = {4'b0, fused_q};
		end
	end

	// decode of the current word
	always_comb begin
		byte_ok  = !cur_q.is_tick && !note_on_q;
		tick_mul = cur_q.is_tick && note_on_q && !silent_q && (fused_q != '0);
		ex_start = 1'b0;
		ex_div   = '0;
		unique case (phase_q)
			PH_DIV_HI: begin
				ex_start = 1'b1;
				ex_div   = {cur_q.data, divlo_q};
			end
			PH_CODE: begin
				if (cur_q.code_silent) begin
					ex_start = 1'b1;
				end else if (cur_q.nib_ok) begin
					ex_start = 1'b1;
					ex_div   = cur_q.code_div;
				end
			end
			default: ;
		endcase
		ex_start = ex_start && byte_ok;
	end

	// period clamp and note arithmetic
	always_comb begin
		per_t   = (div_quo < DIV_NW'(2)) ? DIV_NW'(2) : div_quo;
		per_m   = (per_t[11:0] < 12'd2) ? 12'd2 : per_t[11:0];
		n_half  = len_q[15:1];
		pc_next = {1'b0, pcount_q} + 13'd1;
		si_next = {1'b0, sidx_q} + 17'd1;
		per_fin = nsil_q ? 12'd2 : per_q;
	end

	// next state and divider requests
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q_nonempty) begin
					pop     = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cur_q.is_tick) begin
					if (tick_mul) begin
						state_d = S_MUL;
					end else if (note_on_q) begin
						state_d = S_TICK;
					end else begin
						state_d = S_OUT;
					end
				end else if (ex_start) begin
					if (ex_div == '0) begin
						state_d = S_FIN;
					end else begin
						div_start = 1'b1;
						div_num   = {6'b0, TIMER_HZ};
						div_den   = {5'b0, ex_div};
						state_d   = S_DIV_FREQ;
					end
				end else begin
					state_d = S_OUT;
				end
			end
			S_MUL: begin
				div_start = 1'b1;
				div_num   = {12'b0, amp_c} * {15'b0, k_q};
				div_den   = {9'b0, fused_q};
				state_d   = S_DIV_FADE;
			end
			S_DIV_FADE: begin
				if (div_done) begin
					state_d = S_TICK;
				end
			end
			S_DIV_FREQ: begin
				if (div_done) begin
					if (div_quo == '0) begin
						state_d = S_FIN;
					end else begin
						div_start = 1'b1;
						div_num   = RATE_N;
						div_den   = div_quo[DIV_DW-1:0];
						state_d   = S_DIV_PER;
					end
				end
			end
			S_DIV_PER: begin
				if (div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN, S_TICK: state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers that need no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_entry;
		end
		unique case (state_q)
			S_EXEC: begin
				mag_q  <= silent_q ? 16'd0 : {1'b0, amp_c};
				k_q    <= k_c[11:0];
				len_q  <= len_prod[LEN_SHIFT +: 16];
				nsil_q <= (ex_div == '0);
			end
			S_DIV_FADE: if (div_done) mag_q <= div_quo[15:0];
			S_DIV_FREQ: if (div_done && div_quo == '0) nsil_q <= 1'b1;
			S_DIV_PER: if (div_done) per_q <= per_m;
			default: ;
		endcase
	end

	// configuration, parser and note state, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q       <= AMP_RESET;
			fade_len_q  <= FADE_RESET;
			phase_q     <= PH_HEADER;
			held_q      <= '0;
			divlo_q     <= '0;
			period_q    <= 12'd2;
			half_q      <= 11'd1;
			pcount_q    <= '0;
			sidx_q      <= '0;
			nlen_q      <= '0;
			fused_q     <= '0;
			note_on_q   <= 1'b0;
			silent_q    <= 1'b0;
			p_sample_q  <= '0;
			p_taken_q   <= 1'b0;
			p_started_q <= 1'b0;
			p_skipped_q <= 1'b0;
			p_ended_q   <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_AMPLITUDE: amp_q      <= cfg_data;
					CFG_FADE:      fade_len_q <= cfg_data[11:0];
				endcase
			end

			unique case (state_q)
				// byte parsing and result defaults
				S_EXEC: begin
					p_sample_q  <= '0;
					p_taken_q   <= byte_ok;
					p_started_q <= 1'b0;
					p_skipped_q <= 1'b0;
					p_ended_q   <= 1'b0;
					if (byte_ok) begin
						unique case (phase_q)
							PH_HEADER: begin
								if (cur_q.hdr_end || cur_q.last) begin
									p_ended_q <= 1'b1;
								end else if (cur_q.data <= HDR_LONG_MAX) begin
									held_q  <= cur_q.data;
									phase_q <= PH_DIV_LO;
								end else begin
									held_q  <= cur_q.data - HDR_END;
									phase_q <= PH_CODE;
								end
							end
							PH_DIV_LO: begin
								if (cur_q.last) begin
									p_ended_q <= 1'b1;
									phase_q   <= PH_HEADER;
								end else begin
									divlo_q <= cur_q.data;
									phase_q <= PH_DIV_HI;
								end
							end
							PH_DIV_HI: phase_q <= PH_HEADER;
							PH_CODE: begin
								phase_q <= PH_HEADER;
								if (!cur_q.code_silent && !cur_q.nib_ok) begin
									p_skipped_q <= 1'b1;
								end
							end
						endcase
					end
				end
				// note start
				S_FIN: begin
					if (len_q != '0) begin
						note_on_q   <= 1'b1;
						silent_q    <= nsil_q;
						period_q    <= per_fin;
						half_q      <= per_fin[11:1];
						pcount_q    <= '0;
						sidx_q      <= '0;
						nlen_q      <= len_q;
						fused_q     <= ({3'b0, fade_len_q} > n_half) ? n_half[11:0]
						               : fade_len_q;
						p_started_q <= 1'b1;
					end
				end
				// one sample and counter advance
				S_TICK: begin
					p_sample_q <= (pcount_q < {1'b0, half_q}) ? mag_q : 16'd0 - mag_q;
					pcount_q   <= (pc_next >= {1'b0, period_q}) ? '0 : pc_next[11:0];
					sidx_q     <= si_next[15:0];
					if (si_next >= {1'b0, nlen_q}) begin
						note_on_q <= 1'b0;
					end
				end
				default: ;
			endcase

			// output register
			if (state_q == S_OUT && out_free) begin
				out_q.sample       <= p_sample_q;
				out_q.note_active  <= note_on_q;
				out_q.byte_taken   <= p_taken_q;
				out_q.note_started <= p_started_q;
				out_q.note_skipped <= p_skipped_q;
				out_q.melody_ended <= p_ended_q;
				out_valid_q        <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_period_min: assert property (@(posedge clk) disable iff (!arst_n)
		note_on_q |-> period_q >= 12'd2)
		else $error("period below two while a note plays");
	a_half_len: assert property (@(posedge clk) disable iff (!arst_n)
		note_on_q |-> half_q == period_q[11:1])
		else $error("half period out of step with period");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		note_on_q |-> pcount_q < period_q)
		else $error("phase counter past period");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> out_valid_q)
		else $error("result not presented");
`endif

endmodule

FILE: sv/melody_square_tone_player.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody_square_tone_player: melody parser and square-wave tone generator
// Parses melody bytes into notes and answers each sample tick with a sample.
// ----------------------------------------------------------------------------
// Each input word gives exactly one result word, and the engine works on one
// word at a time. A sample tick of a sounding note with a nonzero fade
// length takes one 27-bit serial divide that scales the amplitude. A byte
// that completes a note gets frequency and then period from two divides on
// the one shared serial divider (the note length is a reciprocal multiply);
// a note with divider zero skips both divides. A stalled result holds the
// engine until it is taken. A two-word queue at the input and a result
// register at the output let the input keep accepting while a result waits
// to be taken.
module melody_square_tone_player import msq_pkg::*; #(
	parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [0:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [7:0]         melody_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample,
	output logic               note_active,
	output logic               byte_taken,
	output logic               note_started,
	output logic               note_skipped,
	output logic               melody_ended
);

	logic              q_full, q_nonempty, push, pop;
	entry_t            wr_entry, rd_entry;
	logic              div_start, div_done;
	logic [DIV_NW-1:0] div_num, div_quo;
	logic [DIV_DW-1:0] div_den;
	result_t           res;

	msq_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.melody_byte (melody_byte),
		.last_byte   (last_byte),
		.q_full      (q_full),
		.push        (push),
		.entry       (wr_entry)
	);

	msq_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	msq_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	msq_back #(.SAMPLE_RATE(SAMPLE_RATE), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_nonempty (q_nonempty),
		.q_entry    (rd_entry),
		.pop        (pop),
		.div_start  (div_start),
		.div_num    (div_num),
		.div_den    (div_den),
		.div_done   (div_done),
		.div_quo    (div_quo),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_res    (res)
	);

	assign sample       = res.sample;
	assign note_active  = res.note_active;
	assign byte_taken   = res.byte_taken;
	assign note_started = res.note_started;
	assign note_skipped = res.note_skipped;
	assign melody_ended = res.melody_ended;

endmodule
